// ===== rtl/tcbs_pkg.sv =====
// Package with the shared types and byte codes of the TSV column block scanner.
`default_nettype none
package tcbs_pkg;

  localparam logic [7:0] BYTE_TAB     = 8'd9;
  localparam logic [7:0] BYTE_NEWLINE = 8'd10;

  localparam logic MODE_DATA  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam int OUT_OFFSET_W = 32;
  localparam int OUT_ROWS_W   = 32;
  localparam int OUT_COLUMN_W = 16;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [OUT_OFFSET_W-1:0] block_offset;
    logic [OUT_ROWS_W-1:0]   row_total;
    logic [OUT_COLUMN_W-1:0] column_total;
    logic                    final_block;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/tcbs_if.sv =====
// Valid/ready channel interfaces for scanner input items and block reports.
`default_nettype none
interface tcbs_item_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface tcbs_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_offset;
  logic [31:0] row_total;
  logic [15:0] column_total;
  logic        final_block;

  modport source (output valid, output block_offset, output row_total,
                  output column_total, output final_block, input ready);
  modport sink (input valid, input block_offset, input row_total,
                input column_total, input final_block, output ready);
endinterface
`default_nettype wire

// ===== rtl/tcbs_in_stage.sv =====
// Input register stage that holds one accepted item until the scan stage takes it.
`default_nettype none
module tcbs_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          valid,
  output logic               ready,
  input  wire tcbs_pkg::item_t item,
  input  wire logic          advance,
  output logic               stage_valid,
  output tcbs_pkg::item_t    stage_item
);

  // The stage can load whenever it is empty or its item moves on this cycle.
  assign ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (ready) begin
      stage_valid <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && valid) begin
      stage_item <= item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tcbs_scan.sv =====
// Scan stage: column and row counters, block tracking and the result register.
`default_nettype none
module tcbs_scan #(
  parameter int OFFSET_BITS = 32,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            stage_valid,
  input  wire tcbs_pkg::item_t stage_item,
  output logic                 advance,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output tcbs_pkg::result_t    res
);

  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [COLUMN_BITS-1:0] current_columns, current_columns_next;
  logic [31:0]            rows_in_block, rows_in_block_next;
  logic [OFFSET_BITS-1:0] block_begin, block_begin_next;
  logic [OFFSET_BITS-1:0] line_begin, line_begin_next;
  logic [COLUMN_BITS-1:0] block_columns, block_columns_next;
  logic                   first_line_pending, first_line_pending_next;

  logic                   emit;
  logic                   emit_final;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [63:0]            offset_wide;
  logic [63:0]            columns_wide;
  tcbs_pkg::result_t      res_next;

  // The result register frees up when it is empty or being taken.
  assign advance = !res_valid || res_ready;

  assign pos_inc = (byte_position == '1) ? byte_position
                                         : byte_position + OFFSET_BITS'(1);

  always_comb begin
    byte_position_next      = byte_position;
    current_columns_next    = current_columns;
    rows_in_block_next      = rows_in_block;
    block_begin_next        = block_begin;
    line_begin_next         = line_begin;
    block_columns_next      = block_columns;
    first_line_pending_next = first_line_pending;
    emit                    = 1'b0;
    emit_final              = 1'b0;

    if (stage_item.mode == tcbs_pkg::MODE_FLUSH) begin
      emit                    = byte_position > block_begin;
      emit_final              = 1'b1;
      byte_position_next      = '0;
      current_columns_next    = COLUMN_BITS'(1);
      rows_in_block_next      = '0;
      block_begin_next        = '0;
      line_begin_next         = '0;
      block_columns_next      = '0;
      first_line_pending_next = 1'b1;
    end else begin
      byte_position_next = pos_inc;
      case (stage_item.data_byte)
        tcbs_pkg::BYTE_TAB: begin
          if (current_columns != '1) begin
            current_columns_next = current_columns + COLUMN_BITS'(1);
          end
        end
        tcbs_pkg::BYTE_NEWLINE: begin
          if (current_columns != block_columns) begin
            // A changed column count closes the running block, except on the first line.
            if (first_line_pending) begin
              first_line_pending_next = 1'b0;
            end else begin
              emit             = 1'b1;
              block_begin_next = line_begin;
            end
            block_columns_next = current_columns;
            rows_in_block_next = 32'd1;
          end else begin
            rows_in_block_next = (rows_in_block == '1) ? rows_in_block
                                                       : rows_in_block + 32'd1;
          end
          line_begin_next      = pos_inc;
          current_columns_next = COLUMN_BITS'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign offset_wide  = 64'(block_begin);
  assign columns_wide = 64'(block_columns);

  always_comb begin
    res_next.block_offset = offset_wide[tcbs_pkg::OUT_OFFSET_W-1:0];
    res_next.row_total    = rows_in_block;
    res_next.column_total = columns_wide[tcbs_pkg::OUT_COLUMN_W-1:0];
    res_next.final_block  = emit_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      current_columns    <= COLUMN_BITS'(1);
      rows_in_block      <= '0;
      block_begin        <= '0;
      line_begin         <= '0;
      block_columns      <= '0;
      first_line_pending <= 1'b1;
      res_valid          <= 1'b0;
    end else if (advance) begin
      res_valid <= stage_valid && emit;
      if (stage_valid) begin
        byte_position      <= byte_position_next;
        current_columns    <= current_columns_next;
        rows_in_block      <= rows_in_block_next;
        block_begin        <= block_begin_next;
        line_begin         <= line_begin_next;
        block_columns      <= block_columns_next;
        first_line_pending <= first_line_pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid && emit) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tsv_column_block_scanner_core.sv =====
// A report passes the input register and then the result register; a result stall can hold it.
// Throughput: one item per cycle while the result side does not stall; the scan stage updates every counter at once.
// A stalled result register holds the scan stage, and the input register then fills.
// Reset (rst, synchronous, active high) clears all counters and empties both registers.
// An end-of-stream transaction reports the open block if it holds bytes and returns the state to reset.
`default_nettype none
module tsv_column_block_scanner_core #(
  parameter int OFFSET_BITS = 32,
  parameter int COLUMN_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  tcbs_item_if.sink     item,
  tcbs_result_if.source result
);

  // The input register stage holds one item, but its ready still follows the result side.
  // The scan stage holds all state of the scanner: byte position, the column count and start
  // of the line in progress, the start and column count of the open block, its rows and a first-line flag.
  tcbs_pkg::item_t   in_item;
  tcbs_pkg::item_t   stage_item;
  tcbs_pkg::result_t res;
  logic              stage_valid;
  logic              advance;
  logic              res_valid;

  always_comb begin
    in_item.mode      = item.mode;
    in_item.data_byte = item.data_byte;
  end

  tcbs_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .valid       (item.valid),
    .ready       (item.ready),
    .item        (in_item),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // A block is reported when a line ends with a column count that differs from the
  // open block's, or when the end-of-stream transaction finds bytes past its start.
  tcbs_scan #(
    .OFFSET_BITS (OFFSET_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .advance     (advance),
    .res_valid   (res_valid),
    .res_ready   (result.ready),
    .res         (res)
  );

  // The result register drives the output channel directly.
  assign result.valid        = res_valid;
  assign result.block_offset = res.block_offset;
  assign result.row_total    = res.row_total;
  assign result.column_total = res.column_total;
  assign result.final_block  = res.final_block;

endmodule
`default_nettype wire

// ===== tb/tsv_column_block_scanner_core_tb.sv =====
// Self-checking testbench for the TSV column block scanner core.
module tsv_column_block_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the block reports of the scanner from the accepted byte stream and
  // checks every report that the block hands out against the oldest prediction.
  class block_report_ledger;
    logic [31:0]       position;
    logic [31:0]       line_start;
    logic [31:0]       block_start;
    logic [31:0]       rows;
    logic [15:0]       line_cols;
    logic [15:0]       block_cols;
    bit                first_line_open;
    tcbs_pkg::result_t expected_reports[$];
    int                mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      position        = '0;
      line_start      = '0;
      block_start     = '0;
      rows            = '0;
      line_cols       = 16'd1;
      block_cols      = '0;
      first_line_open = 1'b1;
    endfunction

    function logic [31:0] bump32(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function void add_expected(tcbs_pkg::result_t r);
      expected_reports = {expected_reports, r};
    endfunction

    function void note_item(logic m, logic [7:0] b);
      if (m == tcbs_pkg::MODE_FLUSH) begin
        if (position > block_start) begin
          add_expected('{block_offset: block_start, row_total: rows,
                         column_total: block_cols, final_block: 1'b1});
        end
        clear();
        return;
      end
      if (b == tcbs_pkg::BYTE_TAB) begin
        if (line_cols != '1) line_cols = line_cols + 16'd1;
      end else if (b == tcbs_pkg::BYTE_NEWLINE) begin
        if (line_cols != block_cols) begin
          if (first_line_open) begin
            first_line_open = 1'b0;
          end else begin
            add_expected('{block_offset: block_start, row_total: rows,
                           column_total: block_cols, final_block: 1'b0});
            block_start = line_start;
          end
          block_cols = line_cols;
          rows       = '0;
        end
        rows       = bump32(rows);
        line_start = bump32(position);
        line_cols  = 16'd1;
      end
      position = bump32(position);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_report(tcbs_pkg::result_t got);
      tcbs_pkg::result_t want;
      if (expected_reports.size() == 0) begin
        report($sformatf("unexpected report offset=%0d rows=%0d cols=%0d last=%0b",
                         got.block_offset, got.row_total, got.column_total,
                         got.final_block));
        return;
      end
      want = expected_reports.pop_front();
      if (got.block_offset !== want.block_offset)
        report($sformatf("block_offset got %0d want %0d", got.block_offset,
                         want.block_offset));
      if (got.row_total !== want.row_total)
        report($sformatf("row_total got %0d want %0d", got.row_total, want.row_total));
      if (got.column_total !== want.column_total)
        report($sformatf("column_total got %0d want %0d", got.column_total,
                         want.column_total));
      if (got.final_block !== want.final_block)
        report($sformatf("final_block got %0b want %0b", got.final_block,
                         want.final_block));
    endtask
  endclass

  // The random part stops once this many byte or flush transactions have gone in.
  localparam int RANDOM_ITEMS = 1500;
  // Cycles in a row with no transaction on either channel before the run is
  // declared hung. The longest legal quiet stretch is a sender gap or a result
  // stall plus the two-register pipeline, so this is far beyond it.
  localparam int HANG_LIMIT = 2000;
  // Extra wait past the pipeline depth; used to let stray reports surface at the end.
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst;

  tcbs_item_if   item_bus();
  tcbs_result_if result_bus();

  tsv_column_block_scanner_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus)
  );

  block_report_ledger board;

  // Idling switches. They are flipped between stretches of stimulus so that
  // the run alternates between back-to-back traffic and randomly gapped traffic.
  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;
  int items_sent = 0;

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sends one transaction. It is always called right after a rising edge at
  // which the previous transaction was accepted (or right after reset), so
  // valid is only touched once per time step: it is either dropped for a gap
  // or simply kept high while the payload changes.
  task automatic send_item(input logic m, input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.mode      <= m;
    item_bus.data_byte <= b;
    do @(posedge clk); while (!(item_bus.valid && item_bus.ready));
    board.note_item(m, b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(tcbs_pkg::MODE_DATA, s[i]);
  endtask

  // Lowers valid and holds the stream back until every predicted report has
  // been seen on the result channel. It waits on the clock before checking, so the next
  // transaction raises valid in a later time step.
  task automatic hold_until_drained();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Cell text: any byte except the two separators.
  function automatic logic [7:0] cell_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == tcbs_pkg::BYTE_TAB || b == tcbs_pkg::BYTE_NEWLINE);
    return b;
  endfunction

  // Receiver side: before each report it draws a random stall with ready low,
  // then waits with ready high until a report is taken.
  // Every accepted report is checked against the prediction right away.
  initial begin
    int stall;
    tcbs_pkg::result_t got;
    result_bus.ready = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = stall_on ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
      got = '{block_offset: result_bus.block_offset, row_total: result_bus.row_total,
              column_total: result_bus.column_total,
              final_block: result_bus.final_block};
      board.check_report(got);
    end
  end

  // Hang detection: any cycle with a transaction on either channel restarts
  // the count.
  always @(posedge clk) begin
    static int quiet_cycles = 0;
    if (rst) begin
      quiet_cycles = 0;
    end else if ((item_bus.valid && item_bus.ready) ||
                 (result_bus.valid && result_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("tsv_column_block_scanner_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int choice;
    int cols;
    int lines;
    int cell_len;
    logic [7:0] b;

    board = new();
    item_bus.valid     = 1'b0;
    item_bus.mode      = tcbs_pkg::MODE_DATA;
    item_bus.data_byte = 8'h00;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A flush on an empty stream must report nothing, even
    // with an all-ones byte sitting in the ignored data field.
    send_item(tcbs_pkg::MODE_FLUSH, 8'hFF);
    // Two lines of two columns form the first block; the first line only
    // opens it. An empty cell between a tab and the newline still counts.
    send_text("a\tb\n");
    send_text("\t\n");
    // Bytes at both ends of the range are plain text. The single-column line
    // closes the two-column block, then a three-column line closes that one.
    send_item(tcbs_pkg::MODE_DATA, 8'h00);
    send_item(tcbs_pkg::MODE_DATA, 8'hFF);
    send_text("\n");
    send_text("\t\t\n");
    // End of stream reports the open block as the last one.
    send_item(tcbs_pkg::MODE_FLUSH, tcbs_pkg::BYTE_NEWLINE);
    // Bytes with no newline at all: the flush reports an empty block at 0.
    send_text("zz");
    send_item(tcbs_pkg::MODE_FLUSH, tcbs_pkg::BYTE_TAB);
    // Empty lines are one-column lines.
    send_text("\n\n");
    send_item(tcbs_pkg::MODE_FLUSH, 8'h00);
    hold_until_drained();

    // Random part. Mostly well-formed blocks of lines with random cell text,
    // mixed with raw byte noise (heavy on separators), flushes that may land
    // mid-line, and pauses that drain the pipeline and reshuffle idling.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        cols  = $urandom_range(1, 4);
        lines = $urandom_range(1, 4);
        repeat (lines) begin
          for (int c = 0; c < cols; c++) begin
            cell_len = $urandom_range(0, 3);
            repeat (cell_len) send_item(tcbs_pkg::MODE_DATA, cell_byte());
            if (c < cols - 1) send_item(tcbs_pkg::MODE_DATA, tcbs_pkg::BYTE_TAB);
          end
          send_item(tcbs_pkg::MODE_DATA, tcbs_pkg::BYTE_NEWLINE);
        end
      end else if (choice < 80) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0)
            b = $urandom_range(0, 1) ? tcbs_pkg::BYTE_TAB : tcbs_pkg::BYTE_NEWLINE;
          else
            b = 8'($urandom_range(0, 255));
          send_item(tcbs_pkg::MODE_DATA, b);
        end
      end else if (choice < 92) begin
        send_item(tcbs_pkg::MODE_FLUSH, 8'($urandom_range(0, 255)));
      end else begin
        hold_until_drained();
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
    end
    item_bus.valid <= 1'b0;

    // Let every predicted report arrive, then wait out the drain time so that
    // any report nobody asked for shows up and is flagged.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tsv_column_block_scanner_core regression: pass");
    end else begin
      $display("tsv_column_block_scanner_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tcbs_pkg.sv
rtl/tcbs_if.sv
rtl/tcbs_in_stage.sv
rtl/tcbs_scan.sv
rtl/tsv_column_block_scanner_core.sv
tb/tsv_column_block_scanner_core_tb.sv
